// ----- hw/rtl/dfd_pkg.sv -----
// shared constants and a helper function for the dwarf field decoder
package dfd_pkg;

    // field kinds as carried by the command on the first beat of a field
    localparam logic [3:0] KIND_U8      = 4'd0;
    localparam logic [3:0] KIND_S8      = 4'd1;
    localparam logic [3:0] KIND_U16     = 4'd2;
    localparam logic [3:0] KIND_U24     = 4'd3;
    localparam logic [3:0] KIND_U32     = 4'd4;
    localparam logic [3:0] KIND_U64     = 4'd5;
    localparam logic [3:0] KIND_OFFSET  = 4'd6;
    localparam logic [3:0] KIND_ADDRESS = 4'd7;
    localparam logic [3:0] KIND_ULEB    = 4'd8;
    localparam logic [3:0] KIND_SLEB    = 4'd9;
    localparam logic [3:0] KIND_INITLEN = 4'd10;

    // result status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW    = 2'd1;
    localparam logic [1:0] ST_LEB_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_BIG_ENDIAN   = 2'd0;
    localparam logic [1:0] REG_OFFSET_64    = 2'd1;
    localparam logic [1:0] REG_ADDRESS_SIZE = 2'd2;

    // leb128 shift bookkeeping
    localparam logic [6:0] LEB_STEP     = 7'd7;
    localparam logic [6:0] LEB_SAT      = 7'd70;
    localparam logic [6:0] LEB_SAT_FROM = 7'd63;
    localparam logic [6:0] LEB_LIMIT    = 7'd64;

    localparam logic [63:0] LEN_ESCAPE = 64'h0000_0000_ffff_ffff;

    // byte length of a fixed-width kind
    function automatic logic [3:0] fixed_len(input logic [3:0] kind);
        logic [3:0] len;
        case (kind)
            KIND_U8:  len = 4'd1;
            KIND_S8:  len = 4'd1;
            KIND_U16: len = 4'd2;
            KIND_U24: len = 4'd3;
            KIND_U32: len = 4'd4;
            KIND_U64: len = 4'd8;
            default:  len = 4'd1;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/dwarf_field_decoder.sv -----
// dwarf field decoder: fixed-width, leb128 and initial length fields, one byte per beat
// output: a result beat is registered and offered in the cycle after the input beat that completes a field
// throughput: one input beat per cycle; the output register takes a new result while the
//   previous one leaves, so the input stalls only when the output side stalls
// reset: synchronous active-low; clears the field state, the output valid and sets the
//   registers to little endian, 4-byte offsets and 8-byte addresses
module dwarf_field_decoder
    import dfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [3:0]  i_cfg_wdata,
    // input byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [3:0]  i_s_axis_tuser,   // [3:0] cmd
    input  logic        i_s_axis_tlast,   // last_in_buffer
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] value
    output logic [2:0]  o_m_axis_tuser    // [1:0] status, [2] wide_format
);

    // configuration registers
    logic       r_big_endian;
    logic       r_offset_64;
    logic [3:0] r_address_size;

    // field state
    logic        r_busy,  n_busy;
    logic [3:0]  r_kind,  n_kind;
    logic [63:0] r_acc,   n_acc;
    logic [3:0]  r_cnt,   n_cnt;
    logic [6:0]  r_shift, n_shift;
    logic        r_ovf,   n_ovf;
    logic        r_long,  n_long;
    logic        r_big,   n_big;

    // output register
    logic        r_out_valid;
    logic [63:0] r_value;
    logic [1:0]  r_status;
    logic        r_wide;

    logic        in_beat;
    logic        emit;
    logic [63:0] e_value;
    logic [1:0]  e_status;
    logic        e_wide;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian   <= 1'b0;
            r_offset_64    <= 1'b0;
            r_address_size <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_BIG_ENDIAN:   r_big_endian   <= i_cfg_wdata[0];
                REG_OFFSET_64:    r_offset_64    <= i_cfg_wdata[0];
                REG_ADDRESS_SIZE: r_address_size <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-beat decode and accumulate
    always_comb begin
        logic        v_go;
        logic [3:0]  v_kind;
        logic [63:0] v_acc;
        logic [3:0]  v_cnt;
        logic [6:0]  v_shift;
        logic        v_ovf;
        logic        v_long;
        logic        v_big;
        logic [3:0]  v_len;
        logic [7:0]  b;

        b        = i_s_axis_tdata;
        n_busy   = r_busy;
        n_kind   = r_kind;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_ovf    = r_ovf;
        n_long   = r_long;
        n_big    = r_big;
        emit     = 1'b0;
        e_value  = 64'd0;
        e_status = ST_OK;
        e_wide   = 1'b0;
        v_go     = 1'b0;
        v_kind   = r_kind;
        v_acc    = r_acc;
        v_cnt    = r_cnt;
        v_shift  = r_shift;
        v_ovf    = r_ovf;
        v_long   = r_long;
        v_big    = r_big;
        v_len    = 4'd1;

        if (in_beat) begin
            v_go = 1'b1;
            if (!r_busy) begin
                // field start: resolve the kind and clear the field state
                case (i_s_axis_tuser)
                    KIND_OFFSET: v_kind = r_offset_64 ? KIND_U64 : KIND_U32;
                    KIND_ADDRESS: begin
                        case (r_address_size)
                            4'd1: v_kind = KIND_U8;
                            4'd2: v_kind = KIND_U16;
                            4'd4: v_kind = KIND_U32;
                            4'd8: v_kind = KIND_U64;
                            default: begin
                                v_go     = 1'b0;
                                emit     = 1'b1;
                                e_status = ST_BAD_ADDR;
                            end
                        endcase
                    end
                    default: begin
                        v_kind = i_s_axis_tuser;
                        if (i_s_axis_tuser > KIND_INITLEN) begin
                            v_go = 1'b0;
                        end
                    end
                endcase
                v_acc   = 64'd0;
                v_cnt   = 4'd0;
                v_shift = 7'd0;
                v_ovf   = 1'b0;
                v_long  = 1'b0;
                v_big   = r_big_endian;
            end

            if (v_go) begin
                if (v_kind == KIND_ULEB || v_kind == KIND_SLEB) begin
                    // leb128: seven payload bits per byte
                    if (v_shift < LEB_LIMIT) begin
                        v_acc = v_acc | ({57'd0, b[6:0]} << v_shift[5:0]);
                    end else begin
                        v_ovf = 1'b1;
                    end
                    v_shift = (v_shift >= LEB_SAT_FROM) ? LEB_SAT : v_shift + LEB_STEP;
                    if (b[7]) begin
                        if (i_s_axis_tlast) begin
                            emit     = 1'b1;
                            e_status = ST_UNDERFLOW;
                        end
                    end else begin
                        if (v_kind == KIND_SLEB && b[6] && v_shift < LEB_LIMIT) begin
                            v_acc = v_acc | ({64{1'b1}} << v_shift[5:0]);
                        end
                        emit     = 1'b1;
                        e_value  = v_acc;
                        e_status = v_ovf ? ST_LEB_OVERFLOW : ST_OK;
                    end
                end else begin
                    // fixed-width and initial length
                    if (v_kind == KIND_INITLEN) begin
                        v_len = v_long ? 4'd8 : 4'd4;
                    end else begin
                        v_len = fixed_len(v_kind);
                    end
                    if (v_big) begin
                        v_acc = {v_acc[55:0], b};
                    end else begin
                        v_acc = v_acc | ({56'd0, b} << {v_cnt[2:0], 3'b000});
                    end
                    v_cnt = v_cnt + 4'd1;
                    if (v_cnt < v_len) begin
                        if (i_s_axis_tlast) begin
                            emit     = 1'b1;
                            e_status = ST_UNDERFLOW;
                            e_wide   = v_long;
                        end
                    end else begin
                        if (v_kind == KIND_S8) begin
                            v_acc = {{56{v_acc[7]}}, v_acc[7:0]};
                        end
                        if (v_kind == KIND_INITLEN && !v_long && v_acc == LEN_ESCAPE) begin
                            // escape word: the real length follows in eight bytes
                            if (i_s_axis_tlast) begin
                                emit     = 1'b1;
                                e_status = ST_UNDERFLOW;
                                e_wide   = 1'b1;
                            end else begin
                                v_long = 1'b1;
                                v_acc  = 64'd0;
                                v_cnt  = 4'd0;
                            end
                        end else begin
                            emit    = 1'b1;
                            e_value = v_acc;
                            e_wide  = v_long;
                        end
                    end
                end
                n_busy  = !emit;
                n_kind  = v_kind;
                n_acc   = v_acc;
                n_cnt   = v_cnt;
                n_shift = v_shift;
                n_ovf   = v_ovf;
                n_long  = v_long;
                n_big   = v_big;
            end
        end
    end

    // field state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_kind  <= KIND_U8;
            r_acc   <= 64'd0;
            r_cnt   <= 4'd0;
            r_shift <= 7'd0;
            r_ovf   <= 1'b0;
            r_long  <= 1'b0;
            r_big   <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_kind  <= n_kind;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_ovf   <= n_ovf;
            r_long  <= n_long;
            r_big   <= n_big;
        end
    end

    // output register: loads a new result beat as the old one leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value  <= e_value;
            r_status <= e_status;
            r_wide   <= e_wide;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_value;
    assign o_m_axis_tuser  = {r_wide, r_status};

endmodule
